[rtl/core/fpfa_pkg.sv]
package fpfa_pkg;

  localparam int MAX_PARTITIONS = 64;
  localparam int NUM_CELLS = (MAX_PARTITIONS < 64) ? MAX_PARTITIONS : 64;

  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int AMT_W  = 16;
  localparam int POL_W  = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_LOADED  = 2'd0,
    STATUS_GRANTED = 2'd1,
    STATUS_NOFIT   = 2'd2,
    STATUS_CLEARED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] partition_index;
    logic [AMT_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [AMT_W-1:0] fragment;
  } result_t;

  // search token moving down the row of cells
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [POL_W-1:0] policy;
    logic [CNT_W-1:0] limit;
    logic [AMT_W-1:0] amount;
    logic [IDX_W-1:0] pick;
    logic [AMT_W-1:0] pick_size;
  } scan_t;

  // broadcast updates to every cell
  typedef struct packed {
    logic             load;
    logic             clear;
    logic             grant;
    logic [IDX_W-1:0] index;
    logic [AMT_W-1:0] amount;
  } ctrl_t;

endpackage

[rtl/core/fpfa_cell.sv]
module fpfa_cell import fpfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  ctrl_t            ctrl_i,
  input  scan_t            scan_i,
  output scan_t            scan_o
);

  logic [AMT_W-1:0] size_q;
  logic             busy_q;
  logic             busy_d;
  scan_t            scan_q;
  scan_t            scan_d;
  logic             hit;
  logic             in_range;
  logic             fits;
  logic             better;
  logic             take;

  assign hit      = (ctrl_i.index == cell_idx_i);
  assign in_range = ({1'b0, cell_idx_i} < scan_i.limit);
  assign fits     = scan_i.valid && in_range && !busy_q && (scan_i.amount <= size_q);

  always_comb begin
    case (scan_i.policy)
      POL_BEST:  better = (size_q < scan_i.pick_size);
      POL_WORST: better = (size_q > scan_i.pick_size);
      default:   better = 1'b0;
    endcase
  end

  assign take = fits && (!scan_i.found || better);

  always_comb begin
    scan_d = scan_i;
    if (take) begin
      scan_d.found     = 1'b1;
      scan_d.pick      = cell_idx_i;
      scan_d.pick_size = size_q;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (ctrl_i.clear) begin
      busy_d = 1'b0;
    end else if (ctrl_i.load && hit) begin
      busy_d = 1'b0;
    end else if (ctrl_i.grant && hit) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      scan_q <= '0;
    end else begin
      busy_q <= busy_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && hit) begin
      size_q <= ctrl_i.amount;
    end
  end

  assign scan_o = scan_q;

endmodule

[rtl/core/fixed_partition_fit_allocator.sv]
// nonzero allocate: busy while the search token walks all NUM_CELLS cells, then result strobe
// load, clear and unused op: result strobe in the cycle after start, busy stays low
// no new item is taken while an allocate search runs; the search token walks the row of
// cells one partition per cycle; other items one per cycle while not busy
// the receiver cannot stall; every result is shown for exactly one cycle
// reset clears busy flags, control flops and scan tokens, not partition sizes or result_q
module fixed_partition_fit_allocator import fpfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  output logic              done_o,
  output result_t           result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic             state_q, state_d;
  logic [POL_W-1:0] policy_q;
  logic [CNT_W-1:0] count_q;
  logic             done_q, done_d;
  result_t          result_q, result_d;
  logic             accept;
  logic             cfg_wr;
  scan_t            seed;
  scan_t            last;
  ctrl_t            ctrl;
  scan_t            chain [NUM_CELLS+1];

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_SCAN);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    seed           = '0;
    seed.valid     = accept && (item_i.op == OP_ALLOC) && (item_i.amount != '0);
    seed.policy    = policy_q;
    seed.limit     = count_q;
    seed.amount    = item_i.amount;
  end

  assign chain[0] = seed;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    fpfa_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .scan_i     (chain[i]),
      .scan_o     (chain[i+1])
    );
  end

  assign last = chain[NUM_CELLS];

  always_comb begin
    ctrl        = '0;
    ctrl.load   = accept && (item_i.op == OP_LOAD);
    ctrl.clear  = accept && (item_i.op == OP_CLEAR);
    ctrl.grant  = last.valid && last.found;
    ctrl.index  = ctrl.grant ? last.pick : item_i.partition_index;
    ctrl.amount = item_i.amount;
  end

  always_comb begin
    result_d = '0;
    done_d   = 1'b0;
    state_d  = state_q;
    if (last.valid) begin
      done_d  = 1'b1;
      state_d = ST_IDLE;
      if (last.found) begin
        result_d.status        = STATUS_GRANTED;
        result_d.granted_index = last.pick;
        result_d.fragment      = last.pick_size - last.amount;
      end else begin
        result_d.status = STATUS_NOFIT;
      end
    end else if (seed.valid) begin
      state_d = ST_SCAN;
    end else if (accept) begin
      done_d = 1'b1;
      case (item_i.op)
        OP_LOAD:  result_d.status = STATUS_LOADED;
        OP_CLEAR: result_d.status = STATUS_CLEARED;
        default:  result_d.status = STATUS_NOFIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      policy_q <= '0;
      count_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_wr) begin
        case (paddr[2])
          REG_POLICY: policy_q <= pwdata[POL_W-1:0];
          REG_COUNT:  count_q  <= pwdata[CNT_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  always_comb begin
    case (paddr[2])
      REG_POLICY: prdata = {{(DATA_W-POL_W){1'b0}}, policy_q};
      REG_COUNT:  prdata = {{(DATA_W-CNT_W){1'b0}}, count_q};
      default:    prdata = '0;
    endcase
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[rtl/core/fpfa_checker.sv]
module fpfa_checker import fpfa_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input item_t   item_i,
  input logic    done_o,
  input result_t result_o
);

  // a result never shows while a search is running
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while busy");

  // a nonzero allocate starts a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op == OP_ALLOC && item_i.amount != '0) |=> busy)
    else $error("allocate item did not start a search");

  // a load item answers loaded in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.op == OP_LOAD) |=> (done_o && result_o.status == STATUS_LOADED))
    else $error("load item not answered");

  // end of search always gives a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(busy) |-> done_o)
    else $error("search ended without result");

  // fields are zero unless granted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != STATUS_GRANTED) |->
    (result_o.granted_index == '0 && result_o.fragment == '0))
    else $error("nonzero fields on a result that is not a grant");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);
